@@ rtl/sincfir_pkg.sv @@
// ---------------------------------------------------------------------------
// sincfir_pkg
// Shared constants, types and coefficient helpers for the symmetric
// sinc low-pass FIR filter.
// ---------------------------------------------------------------------------
`default_nettype none

package sincfir_pkg;

   // filter geometry
   localparam int TAPS            = 21;
   localparam int SAMPLE_BITS     = 16;
   localparam int COEFF_FRAC_BITS = 14;
   localparam int COEFF_BITS      = 16;

   // coefficient registers: four 16-bit slots per 64-bit word
   localparam int CSR_WORDS      = 3;
   localparam int CSR_BITS       = 64;
   localparam int CSR_IDX_BITS   = 2;
   localparam int SLOTS_PER_WORD = CSR_BITS / COEFF_BITS;
   localparam int COEFF_SLOTS    = CSR_WORDS * SLOTS_PER_WORD;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEFF_WORD_0 = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEFF_WORD_1 = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEFF_WORD_2 = 2'd2;

   // datapath widths
   localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
   localparam int TREE_LEVELS = $clog2(TAPS);
   localparam int ACC_BITS    = PROD_BITS + TREE_LEVELS;
   localparam int QUOT_BITS   = ACC_BITS - COEFF_FRAC_BITS;
   localparam int CNT_BITS    = $clog2(TAPS);
   localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;

   // control pipeline: delay line, products, then the adder tree levels
   localparam int STAGES = TREE_LEVELS + 2;

   localparam logic [CNT_BITS-1:0] TAIL_LEN = CNT_BITS'(TAPS - 1);

   // per-transaction control travelling beside the datapath
   typedef struct packed {
      logic valid;
      logic has_result;
      logic last;
   } item_ctl_type;

   // number of nodes on one level of the adder tree
   function automatic int level_count(input int lvl);
      return (TAPS + (1 << lvl) - 1) >> lvl;
   endfunction

   // coefficient of tap j, folded onto its symmetric slot
   function automatic logic signed [COEFF_BITS-1:0] tap_coeff(
      input logic [CSR_WORDS*CSR_BITS-1:0] words,
      input int                            j
   );
      int mirror;
      int slot;
      mirror = TAPS - 1 - j;
      slot   = (j < mirror) ? j : mirror;
      if (slot >= COEFF_SLOTS) begin
         return '0;
      end
      return words[slot*COEFF_BITS +: COEFF_BITS];
   endfunction

endpackage

`default_nettype wire

@@ rtl/sincfir_tap_cell.sv @@
// ---------------------------------------------------------------------------
// sincfir_tap_cell
// One tap of the delay chain: holds a sample, passes it on to the next
// cell and registers its coefficient product.
// ---------------------------------------------------------------------------
`default_nettype none

module sincfir_tap_cell (
   input  wire                                           clock,
   input  wire                                           advance,
   input  wire                                           shift,
   input  wire  signed [sincfir_pkg::SAMPLE_BITS-1:0]   sample_in,
   input  wire  signed [sincfir_pkg::COEFF_BITS-1:0]    coeff,
   output logic signed [sincfir_pkg::SAMPLE_BITS-1:0]   sample_out,
   output logic signed [sincfir_pkg::PROD_BITS-1:0]     product_out
);

   logic signed [sincfir_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic signed [sincfir_pkg::PROD_BITS-1:0]   product_ff;

   // delay element, moves only when a sample is taken in
   always_ff @(posedge clock) begin
      if (shift) begin
         sample_ff <= sample_in;
      end
   end

   // tap product, captured whenever the pipeline moves
   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff <= coeff * sample_ff;
      end
   end

   assign sample_out  = sample_ff;
   assign product_out = product_ff;

endmodule

`default_nettype wire

@@ rtl/sincfir_adder_tree.sv @@
// ---------------------------------------------------------------------------
// sincfir_adder_tree
// Registered pairwise adder tree summing the tap products, one level per
// pipeline stage.
// ---------------------------------------------------------------------------
`default_nettype none

module sincfir_adder_tree (
   input  wire                                          clock,
   input  wire                                          advance,
   input  wire  signed [sincfir_pkg::PROD_BITS-1:0]    products [sincfir_pkg::TAPS],
   output logic signed [sincfir_pkg::ACC_BITS-1:0]     sum_out
);

   // level 0 holds the sign-extended products, level l the l-th register rank
   logic signed [sincfir_pkg::ACC_BITS-1:0]
      level_q [sincfir_pkg::TREE_LEVELS+1][sincfir_pkg::TAPS];

   genvar l, i;

   // leaves
   generate
      for (i = 0; i < sincfir_pkg::TAPS; i++) begin : g_leaf
         assign level_q[0][i] = sincfir_pkg::ACC_BITS'(products[i]);
      end
   endgenerate

   // register ranks
   generate
      for (l = 0; l < sincfir_pkg::TREE_LEVELS; l++) begin : g_level
         for (i = 0; i < sincfir_pkg::TAPS; i++) begin : g_node
            if (i < sincfir_pkg::level_count(l + 1)) begin : g_used
               logic signed [sincfir_pkg::ACC_BITS-1:0] sum_ff;
               if (2 * i + 1 < sincfir_pkg::level_count(l)) begin : g_pair
                  always_ff @(posedge clock) begin
                     if (advance) begin
                        sum_ff <= level_q[l][2*i] + level_q[l][2*i+1];
                     end
                  end
               end else begin : g_single
                  always_ff @(posedge clock) begin
                     if (advance) begin
                        sum_ff <= level_q[l][2*i];
                     end
                  end
               end
               assign level_q[l+1][i] = sum_ff;
            end else begin : g_unused
               assign level_q[l+1][i] = '0;
            end
         end
      end
   endgenerate

   assign sum_out = level_q[sincfir_pkg::TREE_LEVELS][0];

endmodule

`default_nettype wire

@@ rtl/sinc_lowpass_fir_21_tap.sv @@
// ---------------------------------------------------------------------------
// sinc_lowpass_fir_21_tap
// Symmetric 21-tap low-pass FIR with truncate-toward-zero, 16-bit
// saturation, warm-up suppression and a zero tail after the last sample.
// ---------------------------------------------------------------------------
// One sample is taken per clock while no zero tail is sent and the result
// side does not stall. Each sample shifts a chain of 21 tap cells; each cell
// multiplies its sample by its folded coefficient, and a registered adder
// tree sums the products, so a result passes the delay register, the product
// register, the adder tree levels and the output register. The first 20
// samples of a pass give no result. A sample with tlast set gives its result
// (if the line is full) followed by 20 zero results, the final one with
// tlast; while it is sent, one result per cycle unless the result side
// stalls, no sample is taken. A stall on the result side stalls the whole
// pipeline in lockstep. The user must write coefficients between transactions;
// the block does not enforce it. They apply to the whole delay line at once.
// ---------------------------------------------------------------------------
`default_nettype none

module sinc_lowpass_fir_21_tap (
   input  wire                                           clock,
   input  wire                                           reset,
   // input samples
   input  wire                                           req_tvalid,
   output logic                                          req_tready,
   input  wire  [sincfir_pkg::DATA_BITS-1:0]             req_tdata,   // [15:0] sample
   input  wire                                           req_tlast,   // last_sample
   // filtered results
   output logic                                          rsp_tvalid,
   input  wire                                           rsp_tready,
   output logic [sincfir_pkg::DATA_BITS-1:0]             rsp_tdata,   // [15:0] filtered
   output logic                                          rsp_tuser,   // [0] clipped
   output logic                                          rsp_tlast,   // last_out
   // coefficient registers
   input  wire                                           csr_wen,
   input  wire  [sincfir_pkg::CSR_IDX_BITS-1:0]          csr_index,
   input  wire  [sincfir_pkg::CSR_BITS-1:0]              csr_wdata
);

   localparam int SB = sincfir_pkg::SAMPLE_BITS;

   // coefficient words
   logic [sincfir_pkg::CSR_BITS-1:0]                   coeff_ff [sincfir_pkg::CSR_WORDS];
   logic [sincfir_pkg::CSR_WORDS*sincfir_pkg::CSR_BITS-1:0] coeff_bus;

   // delay chain
   logic signed [SB-1:0]                         tap_sample  [sincfir_pkg::TAPS];
   logic signed [sincfir_pkg::PROD_BITS-1:0]     tap_product [sincfir_pkg::TAPS];
   logic signed [sincfir_pkg::ACC_BITS-1:0]      acc_sum;

   // control pipeline
   sincfir_pkg::item_ctl_type ctl_ff [sincfir_pkg::STAGES];
   sincfir_pkg::item_ctl_type end_ctl;
   logic [sincfir_pkg::CNT_BITS-1:0] warmup_ff, warmup_in;
   logic [sincfir_pkg::CNT_BITS-1:0] tail_ff, tail_in;
   logic advance;
   logic accept;
   logic tail_busy;
   logic out_free;

   // rounding and saturation
   logic signed [sincfir_pkg::ACC_BITS-1:0]  bias;
   logic signed [sincfir_pkg::ACC_BITS-1:0]  adj_sum;
   logic signed [sincfir_pkg::QUOT_BITS-1:0] quot;
   logic [sincfir_pkg::QUOT_BITS-SB:0]       quot_hi;
   logic                                     overflow;
   logic [SB-1:0]                            sat_value;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [SB-1:0] out_data_ff,  out_data_in;
   logic          out_clip_ff,  out_clip_in;
   logic          out_last_ff,  out_last_in;

   // coefficient register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < sincfir_pkg::CSR_WORDS; w++) begin
            coeff_ff[w] <= '0;
         end
      end else if (csr_wen) begin
         case (csr_index)
            sincfir_pkg::CSR_COEFF_WORD_0: coeff_ff[0] <= csr_wdata;
            sincfir_pkg::CSR_COEFF_WORD_1: coeff_ff[1] <= csr_wdata;
            sincfir_pkg::CSR_COEFF_WORD_2: coeff_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int w = 0; w < sincfir_pkg::CSR_WORDS; w++) begin
         coeff_bus[w*sincfir_pkg::CSR_BITS +: sincfir_pkg::CSR_BITS] = coeff_ff[w];
      end
   end

   // pipeline moves unless a tail is running or a result cannot leave
   assign end_ctl    = ctl_ff[sincfir_pkg::STAGES-1];
   assign tail_busy  = (tail_ff != '0);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = !tail_busy && (!end_ctl.valid || !end_ctl.has_result || out_free);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // tap chain
   genvar g;
   generate
      for (g = 0; g < sincfir_pkg::TAPS; g++) begin : g_tap
         if (g == 0) begin : g_head
            sincfir_tap_cell u_cell (
               .clock       (clock),
               .advance     (advance),
               .shift       (accept),
               .sample_in   (req_tdata[SB-1:0]),
               .coeff       (sincfir_pkg::tap_coeff(coeff_bus, g)),
               .sample_out  (tap_sample[g]),
               .product_out (tap_product[g])
            );
         end else begin : g_body
            sincfir_tap_cell u_cell (
               .clock       (clock),
               .advance     (advance),
               .shift       (accept),
               .sample_in   (tap_sample[g-1]),
               .coeff       (sincfir_pkg::tap_coeff(coeff_bus, g)),
               .sample_out  (tap_sample[g]),
               .product_out (tap_product[g])
            );
         end
      end
   endgenerate

   sincfir_adder_tree u_tree (
      .clock    (clock),
      .advance  (advance),
      .products (tap_product),
      .sum_out  (acc_sum)
   );

   // warm-up count of the current pass
   always_comb begin
      warmup_in = warmup_ff;
      if (accept) begin
         if (req_tlast) begin
            warmup_in = '0;
         end else if (warmup_ff != sincfir_pkg::TAIL_LEN) begin
            warmup_in = warmup_ff + 1'b1;
         end
      end
   end

   // control travelling beside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff <= '0;
         for (int s = 0; s < sincfir_pkg::STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         warmup_ff <= warmup_in;
         if (advance) begin
            ctl_ff[0].valid      <= accept;
            ctl_ff[0].has_result <= (warmup_ff == sincfir_pkg::TAIL_LEN);
            ctl_ff[0].last       <= req_tlast;
            for (int s = 1; s < sincfir_pkg::STAGES; s++) begin
               ctl_ff[s] <= ctl_ff[s-1];
            end
         end
      end
   end

   // truncate toward zero, then saturate
   always_comb begin
      bias = '0;
      if (acc_sum[sincfir_pkg::ACC_BITS-1]) begin
         bias[sincfir_pkg::COEFF_FRAC_BITS-1:0] = '1;
      end
      adj_sum  = acc_sum + bias;
      quot     = adj_sum[sincfir_pkg::ACC_BITS-1:sincfir_pkg::COEFF_FRAC_BITS];
      quot_hi  = quot[sincfir_pkg::QUOT_BITS-1:SB-1];
      overflow = !(&quot_hi) && (|quot_hi);
      if (overflow) begin
         sat_value = quot[sincfir_pkg::QUOT_BITS-1] ? {1'b1, {(SB-1){1'b0}}}
                                                    : {1'b0, {(SB-1){1'b1}}};
      end else begin
         sat_value = quot[SB-1:0];
      end
   end

   // output register and zero tail
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_clip_in  = out_clip_ff;
      out_last_in  = out_last_ff;
      tail_in      = tail_ff;
      if (tail_busy) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = '0;
            out_clip_in  = 1'b0;
            out_last_in  = (tail_ff == sincfir_pkg::CNT_BITS'(1));
            tail_in      = tail_ff - 1'b1;
         end
      end else if (advance && end_ctl.valid) begin
         if (end_ctl.has_result) begin
            out_valid_in = 1'b1;
            out_data_in  = sat_value;
            out_clip_in  = overflow;
            out_last_in  = 1'b0;
         end
         if (end_ctl.last) begin
            tail_in = sincfir_pkg::TAIL_LEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         tail_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_clip_ff <= out_clip_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      rsp_tdata         = '0;
      rsp_tdata[SB-1:0] = out_data_ff;
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_clip_ff;
   assign rsp_tlast  = out_last_ff;

   // no sample is taken while the tail is being sent
   assert property (@(posedge clock) disable iff (reset)
      tail_busy |-> !req_tready)
      else $error("sample taken during zero tail");

   // the final result of a pass is a tail zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[SB-1:0] == '0 && !rsp_tuser))
      else $error("final result is not a clean tail zero");

   // a clipped result sits on one of the two limits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[SB-1:0] == {1'b1, {(SB-1){1'b0}}} ||
          rsp_tdata[SB-1:0] == {1'b0, {(SB-1){1'b1}}}))
      else $error("clip flag without a saturated value");

   // warm-up count saturates at the line length less one
   assert property (@(posedge clock) disable iff (reset)
      warmup_ff <= sincfir_pkg::TAIL_LEN)
      else $error("warm-up count out of range");

   // a tail only starts when a last transaction leaves the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (!tail_busy ##1 tail_busy) |-> $past(advance && end_ctl.valid && end_ctl.last))
      else $error("zero tail started without a last transaction");

endmodule

`default_nettype wire
